@@ rtl/longest_remaining_time_scheduler_defines.svh @@
// assertion macros for the longest remaining time scheduler
// used by lrts_ctrl, needs clk_i and rst_ni in the including module
`ifndef LONGEST_REMAINING_TIME_SCHEDULER_DEFINES_SVH
`define LONGEST_REMAINING_TIME_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define LRTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lrts assertion failed");

// next-cycle implication
`define LRTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lrts assertion failed");

`endif

@@ rtl/lrts_pkg.sv @@
// shared types and constants for the longest remaining time scheduler
// no dependencies
package lrts_pkg;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned BURST_BITS = 16;
  localparam logic [31:0] BURST_MAX  = 32'((64'd1 << BURST_BITS) - 64'd1);

  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  typedef enum logic [1:0] {
    EV_ACCEPT = 2'd0,
    EV_FULL   = 2'd1,
    EV_IDLE   = 2'd2,
    EV_RAN    = 2'd3
  } event_res_e;

  typedef struct packed {
    logic        command;
    logic [7:0]  proc_id;
    logic [15:0] burst_len;
  } in_item_t;

  typedef struct packed {
    event_res_e  event_res;
    logic [7:0]  run_id;
    logic        first_run;
    logic        finished;
    logic [15:0] remaining_after;
    logic [31:0] tick_time;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

endpackage

@@ rtl/longest_remaining_time_scheduler.sv @@
// top level of the longest remaining time first scheduler
// depends on lrts_pkg, lrts_ctrl and lrts_dp
//
//   channel  direction  payload      handshake
//   in       input      in_item_t    in_valid_i / in_stall_o
//   out      output     out_item_t   out_valid_o / out_stall_i
//
// each item passes through accept, a table scan of one slot per cycle, and then a commit
// step that updates the slot and loads the result
// reset clears slot valid bits, the time count and the control state at once
// the result register holds while out_stall_i is high; commit waits for it to empty
// in_stall_o is high from accept until commit
module longest_remaining_time_scheduler import lrts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  lrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  lrts_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .out_item_o (out_item_o)
  );

endmodule

@@ rtl/lrts_dp.sv @@
// datapath: slot table, time counter, slot scan and result register
// depends on lrts_pkg
module lrts_dp import lrts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output out_item_t out_item_o
);

  logic [SLOTS-1:0]      slot_valid_q;
  logic [7:0]            slot_proc_q  [SLOTS];
  logic [BURST_BITS-1:0] slot_rem_q   [SLOTS];
  logic                  slot_started_q [SLOTS];
  logic [31:0]           slot_start_q [SLOTS];
  logic [31:0]           time_q;

  logic                  cmd_q;
  logic [7:0]            pid_q;
  logic [BURST_BITS-1:0] burst_q;
  logic [SLOT_W-1:0]     idx_q;
  logic                  found_q;
  logic [SLOT_W-1:0]     best_idx_q;
  logic [BURST_BITS-1:0] best_rem_q;
  logic                  best_started_q;
  logic [31:0]           best_start_q;
  logic [7:0]            best_proc_q;
  out_item_t             out_q;
  out_item_t             out_d;

  logic [BURST_BITS-1:0] burst_sat;
  logic [BURST_BITS-1:0] cur_rem;
  logic                  cur_started;
  logic [31:0]           cur_start;
  logic                  rem_gt, rem_eq, take_tick, take_arr, take;
  logic [BURST_BITS-1:0] new_rem;
  logic                  is_done;

  always_comb begin
    if (32'(in_item_i.burst_len) > BURST_MAX) begin
      burst_sat = BURST_BITS'(BURST_MAX);
    end else begin
      burst_sat = BURST_BITS'(in_item_i.burst_len);
    end
  end

  assign cur_rem     = slot_rem_q[idx_q];
  assign cur_started = slot_started_q[idx_q];
  assign cur_start   = slot_start_q[idx_q];
  assign rem_gt      = cur_rem > best_rem_q;
  assign rem_eq      = cur_rem == best_rem_q;
  assign take_tick   = slot_valid_q[idx_q] && (!found_q || rem_gt ||
                       (rem_eq && cur_started && !best_started_q) ||
                       (rem_eq && cur_started && best_started_q && cur_start > best_start_q));
  assign take_arr    = !slot_valid_q[idx_q] && !found_q;
  assign take        = (cmd_q == CMD_TICK) ? take_tick : take_arr;
  assign new_rem     = best_rem_q - BURST_BITS'(1);
  assign is_done     = new_rem == '0;

  assign sts_o.scan_last = idx_q == SLOT_W'(SLOTS - 1);
  assign out_item_o      = out_q;

  // item capture and scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= in_item_i.command;
      pid_q   <= in_item_i.proc_id;
      burst_q <= burst_sat;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + SLOT_W'(1);
      if (take) begin
        found_q        <= 1'b1;
        best_idx_q     <= idx_q;
        best_rem_q     <= cur_rem;
        best_started_q <= cur_started;
        best_start_q   <= cur_start;
        best_proc_q    <= slot_proc_q[idx_q];
      end
    end
  end

  // result of the item in flight
  always_comb begin
    out_d           = '0;
    out_d.tick_time = time_q;
    if (cmd_q == CMD_ARRIVAL) begin
      out_d.run_id = pid_q;
      if (burst_q == '0) begin
        out_d.event_res = EV_ACCEPT;
      end else if (found_q) begin
        out_d.event_res       = EV_ACCEPT;
        out_d.remaining_after = 16'(burst_q);
      end else begin
        out_d.event_res = EV_FULL;
      end
    end else if (!found_q) begin
      out_d.event_res = EV_IDLE;
    end else begin
      out_d.event_res       = EV_RAN;
      out_d.run_id          = best_proc_q;
      out_d.first_run       = !best_started_q;
      out_d.finished        = is_done;
      out_d.remaining_after = 16'(new_rem);
    end
  end

  // slot payload and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= out_d;
      if (cmd_q == CMD_ARRIVAL) begin
        if (burst_q != '0 && found_q) begin
          slot_proc_q[best_idx_q]    <= pid_q;
          slot_rem_q[best_idx_q]     <= burst_q;
          slot_started_q[best_idx_q] <= 1'b0;
          slot_start_q[best_idx_q]   <= '0;
        end
      end else if (found_q) begin
        slot_rem_q[best_idx_q] <= new_rem;
        if (!best_started_q) begin
          slot_started_q[best_idx_q] <= 1'b1;
          slot_start_q[best_idx_q]   <= time_q;
        end
      end
    end
  end

  // valid bits and time count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      time_q       <= '0;
    end else if (cmd_i.commit) begin
      if (cmd_q == CMD_ARRIVAL) begin
        if (burst_q != '0 && found_q) begin
          slot_valid_q[best_idx_q] <= 1'b1;
        end
      end else begin
        time_q <= time_q + 32'd1;
        if (found_q && is_done) begin
          slot_valid_q[best_idx_q] <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/lrts_ctrl.sv @@
// controller: accept, slot scan and commit sequencing, output valid
// depends on lrts_pkg and longest_remaining_time_scheduler_defines.svh
`include "longest_remaining_time_scheduler_defines.svh"
module lrts_ctrl import lrts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `LRTS_ASSERT_NEXT(a_accept_scan, in_valid_i && !in_stall_o, state_q == S_SCAN)
  `LRTS_ASSERT_NEXT(a_scan_end, state_q == S_SCAN && sts_i.scan_last, state_q == S_COMMIT)
  `LRTS_ASSERT_NOW(a_valid_from_commit, $rose(out_valid_q), $past(state_q) == S_COMMIT)
  `LRTS_ASSERT_NEXT(a_commit_shows, cmd_o.commit, out_valid_q && state_q == S_IDLE)

endmodule

@@ dv/longest_remaining_time_scheduler_test.sv @@
// self-checking testbench for the longest remaining time first scheduler
// predicts every result item in a scoreboard class and drives both channels with random idling
// depends on lrts_pkg and the longest_remaining_time_scheduler rtl
module longest_remaining_time_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lrts_pkg::*;

  localparam int unsigned RAND_ITEMS     = 1500;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = SLOTS + 8;

  class sched_scoreboard;
    logic        busy     [SLOTS];
    logic [7:0]  owner    [SLOTS];
    logic [31:0] remain   [SLOTS];
    logic        begun    [SLOTS];
    logic [31:0] begun_at [SLOTS];
    logic [31:0] clock_count;
    out_item_t   due_q[$];
    int unsigned mismatches;

    function new();
      foreach (busy[i]) begin
        busy[i]     = 1'b0;
        owner[i]    = '0;
        remain[i]   = '0;
        begun[i]    = 1'b0;
        begun_at[i] = '0;
      end
      clock_count = '0;
      mismatches  = 0;
    endfunction

    function bit wins(int unsigned a, int unsigned b);
      if (remain[a] != remain[b]) return remain[a] > remain[b];
      if (begun[a] != begun[b]) return begun[a];
      if (begun[a] && begun_at[a] != begun_at[b]) return begun_at[a] > begun_at[b];
      return 1'b0;
    endfunction

    function int unsigned occupied();
      int unsigned n;
      n = 0;
      foreach (busy[i]) if (busy[i]) n++;
      return n;
    endfunction

    // ticks still owed to stored processes
    function int unsigned backlog();
      int unsigned n;
      n = 0;
      foreach (busy[i]) if (busy[i]) n += remain[i];
      return n;
    endfunction

    function int unsigned waiting();
      return due_q.size();
    endfunction

    function void note_input(in_item_t item);
      out_item_t   want;
      logic [31:0] burst;
      int          pick;
      want = '0;
      want.tick_time = clock_count;
      pick = -1;
      if (item.command == CMD_ARRIVAL) begin
        want.run_id = item.proc_id;
        burst = 32'(item.burst_len);
        if (burst > BURST_MAX) burst = BURST_MAX;
        for (int i = 0; i < SLOTS; i++) if (!busy[i] && pick < 0) pick = i;
        if (burst == 0) begin
          want.event_res = EV_ACCEPT;
        end else if (pick >= 0) begin
          busy[pick]     = 1'b1;
          owner[pick]    = item.proc_id;
          remain[pick]   = burst;
          begun[pick]    = 1'b0;
          begun_at[pick] = '0;
          want.event_res = EV_ACCEPT;
          want.remaining_after = burst[15:0];
        end else begin
          want.event_res = EV_FULL;
        end
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (busy[i] && (pick < 0 || wins(i, pick))) pick = i;
        end
        if (pick < 0) begin
          want.event_res = EV_IDLE;
        end else begin
          want.event_res = EV_RAN;
          want.run_id = owner[pick];
          if (!begun[pick]) begin
            want.first_run = 1'b1;
            begun[pick]    = 1'b1;
            begun_at[pick] = clock_count;
          end
          if (remain[pick] != 0) remain[pick]--;
          if (remain[pick] == 0) begin
            want.finished = 1'b1;
            busy[pick]    = 1'b0;
          end
          want.remaining_after = remain[pick][15:0];
        end
        clock_count++;
      end
      due_q = {due_q, want};
    endfunction

    task report(string msg);
      mismatches++;
      $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (due_q.size() == 0) begin
        report($sformatf("result item %0h with nothing expected", got));
      end else begin
        want = due_q.pop_front();
        if (got.event_res !== want.event_res)
          report($sformatf("event_res got %0d expected %0d", got.event_res, want.event_res));
        if (got.run_id !== want.run_id)
          report($sformatf("run_id got %0h expected %0h", got.run_id, want.run_id));
        if (got.first_run !== want.first_run)
          report($sformatf("first_run got %0b expected %0b", got.first_run, want.first_run));
        if (got.finished !== want.finished)
          report($sformatf("finished got %0b expected %0b", got.finished, want.finished));
        if (got.remaining_after !== want.remaining_after)
          report($sformatf("remaining_after got %0d expected %0d",
                           got.remaining_after, want.remaining_after));
        if (got.tick_time !== want.tick_time)
          report($sformatf("tick_time got %0d expected %0d", got.tick_time, want.tick_time));
      end
    endtask
  endclass

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      in_valid   = 1'b0;
  in_item_t  in_item    = '0;
  logic      out_stall  = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  sched_scoreboard sb = new();

  bit          calm       = 1'b0;
  bit          steady_in  = 1'b0;
  bit          steady_out = 1'b0;
  int unsigned stall_run  = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent  = 0;

  longest_remaining_time_scheduler uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (stall_run != 0) begin
        stall_run--;
        out_stall <= 1'b1;
      end else if (!out_stall && !calm && !steady_out && $urandom_range(0, 4) == 0) begin
        stall_run = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("longest_remaining_time_scheduler_test NOT OK");
      $finish;
    end
  end

  function automatic in_item_t arrival(logic [7:0] pid, logic [15:0] burst);
    in_item_t item;
    item.command   = CMD_ARRIVAL;
    item.proc_id   = pid;
    item.burst_len = burst;
    return item;
  endfunction

  function automatic in_item_t tick();
    in_item_t item;
    item.command   = CMD_TICK;
    item.proc_id   = 8'($urandom);
    item.burst_len = 16'($urandom);
    return item;
  endfunction

  function automatic int unsigned pick_gap();
    if (calm || steady_in || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] pick_burst();
    int unsigned r;
    if (sb.occupied() == SLOTS) return 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 5) return 16'd0;
    if (r < 80) return 16'($urandom_range(1, 6));
    if (r < 95) return 16'($urandom_range(7, 40));
    return 16'($urandom_range(41, 200));
  endfunction

  // valid stays high from one item to the next unless a gap is wanted
  task automatic push_item(input in_item_t item, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(item);
    items_sent++;
  endtask

  task automatic hold_off();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.waiting() != 0);
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned share;
    in_item_t    item;
    case ($urandom_range(0, 2))
      0:       share = 65;
      1:       share = 35;
      default: share = 12;
    endcase
    steady_in  = ($urandom_range(0, 3) == 0);
    steady_out = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      if ($urandom_range(0, 99) < share) item = arrival(8'($urandom), pick_burst());
      else item = tick();
      push_item(item, pick_gap());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle tick with junk payload, zero burst, then a tie between unstarted
    // and between started processes
    push_item(arrival(8'hFF, 16'hFFFF) | in_item_t'({CMD_TICK, 24'd0}), pick_gap());
    push_item(arrival(8'h00, 16'h0000), pick_gap());
    push_item(arrival(8'hFF, 16'd2), pick_gap());
    push_item(arrival(8'h55, 16'd2), pick_gap());
    repeat (4) push_item(tick(), pick_gap());
    push_item(tick(), pick_gap());
    // fill the table, then a refused arrival and a zero burst while full
    for (int k = 0; k < SLOTS; k++) push_item(arrival(8'(k * 17), 16'((k % 3) + 1)), pick_gap());
    push_item(arrival(8'hA5, 16'hFFFF), pick_gap());
    push_item(arrival(8'h5A, 16'h0000), pick_gap());
    hold_off();

    // the drain below sends one tick per owed tick, so count it in
    while (items_sent + sb.backlog() < RAND_ITEMS) begin
      random_phase($urandom_range(20, 80));
      if ($urandom_range(0, 3) == 0) hold_off();
    end

    calm = 1'b1;
    steady_in = 1'b1;
    while (sb.occupied() != 0) push_item(tick(), 0);
    push_item(arrival(8'hC3, 16'hFFFF), 0);
    push_item(arrival(8'h3C, 16'h8000), 0);
    push_item(arrival(8'h0F, 16'h7FFF), 0);
    repeat (4) push_item(tick(), 0);

    in_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("longest_remaining_time_scheduler_test OK");
    end else begin
      $display("longest_remaining_time_scheduler_test NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lrts_pkg.sv
rtl/lrts_dp.sv
rtl/lrts_ctrl.sv
rtl/longest_remaining_time_scheduler.sv
dv/longest_remaining_time_scheduler_test.sv
